/* hw/rtl/xdm_pkg.sv */
// X-drive wheel mixer: shared widths, constants and pipeline payload types.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package xdm_pkg;

  localparam int SPD_W     = 12;
  localparam int SUM_W     = 13;
  localparam int COEF_W    = 15;
  localparam int PROD_W    = 28;
  localparam int RND_W     = 13;
  localparam int WHL_W     = 14;
  localparam int MAG_W     = 13;
  localparam int LIM_W     = 11;
  localparam int NUM_W     = 24;
  localparam int Q_W       = 11;
  localparam int LANES     = 4;
  localparam int MIX_SHIFT = 15;
  localparam int NSTG      = 4 + Q_W + 1;

  localparam logic [COEF_W-1:0] MIX_COEF = 15'd23170;
  localparam logic [PROD_W-1:0] MIX_HALF = 28'd16384;
  localparam logic [LIM_W-1:0]  LIM_RST  = 11'd600;

  localparam int WHL_FL = 0;
  localparam int WHL_FR = 1;
  localparam int WHL_BL = 2;
  localparam int WHL_BR = 3;

  typedef logic signed [SPD_W-1:0] spd_t;
  typedef logic signed [WHL_W-1:0] whl_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
    logic [Q_W-1:0]   pass;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic [NUM_W-1:0]  dvsr;
    logic              scaled;
  } div_t;

endpackage

`default_nettype wire

/* hw/rtl/xdm_in_if.sv */
// Command channel of the X-drive wheel mixer: valid/ready plus three speeds.
// Depends on xdm_pkg for the speed type.
`default_nettype none

interface xdm_in_if;
  logic          valid;
  logic          ready;
  xdm_pkg::spd_t forward_speed;
  xdm_pkg::spd_t sideways_speed;
  xdm_pkg::spd_t turn_speed;

  modport source(output valid, output forward_speed, output sideways_speed,
                 output turn_speed, input ready);
  modport sink(input valid, input forward_speed, input sideways_speed,
               input turn_speed, output ready);
endinterface

`default_nettype wire

/* hw/rtl/xdm_out_if.sv */
// Result channel of the X-drive wheel mixer: valid/ready, four wheel speeds
// and the scaled flag. Depends on xdm_pkg for the speed type.
`default_nettype none

interface xdm_out_if;
  logic          valid;
  logic          ready;
  xdm_pkg::spd_t front_left_speed;
  xdm_pkg::spd_t front_right_speed;
  xdm_pkg::spd_t back_left_speed;
  xdm_pkg::spd_t back_right_speed;
  logic          was_scaled;

  modport source(output valid, output front_left_speed, output front_right_speed,
                 output back_left_speed, output back_right_speed,
                 output was_scaled, input ready);
  modport sink(input valid, input front_left_speed, input front_right_speed,
               input back_left_speed, input back_right_speed,
               input was_scaled, output ready);
endinterface

`default_nettype wire

/* hw/rtl/xdm_mix.sv */
// Mixing stages: 45 degree rotation of the translation (Q0.15, rounded) and
// per-wheel turn add/subtract. Two register stages. Depends on xdm_pkg.
`default_nettype none

module xdm_mix (
  input  logic                                clk,
  input  logic                                en_s0,
  input  logic                                en_s1,
  input  xdm_pkg::spd_t                       fwd,
  input  xdm_pkg::spd_t                       side,
  input  xdm_pkg::spd_t                       turn,
  output xdm_pkg::whl_t [xdm_pkg::LANES-1:0]  whl_r
);

  logic signed [xdm_pkg::SUM_W-1:0]  sum_a;
  logic signed [xdm_pkg::SUM_W-1:0]  sum_b;
  logic [xdm_pkg::SUM_W-1:0]         mag_a;
  logic [xdm_pkg::SUM_W-1:0]         mag_b;
  logic [xdm_pkg::PROD_W-1:0]        prod_a_nxt;
  logic [xdm_pkg::PROD_W-1:0]        prod_b_nxt;

  logic [xdm_pkg::PROD_W-1:0]        prod_a_r;
  logic [xdm_pkg::PROD_W-1:0]        prod_b_r;
  logic                              neg_a_r;
  logic                              neg_b_r;
  xdm_pkg::spd_t                     turn_r;

  logic [xdm_pkg::PROD_W-1:0]        rnd_a;
  logic [xdm_pkg::PROD_W-1:0]        rnd_b;
  logic [xdm_pkg::RND_W-1:0]         dg_a;
  logic [xdm_pkg::RND_W-1:0]         dg_b;
  xdm_pkg::whl_t                     da;
  xdm_pkg::whl_t                     db;
  xdm_pkg::whl_t                     tw;
  xdm_pkg::whl_t [xdm_pkg::LANES-1:0] whl_nxt;

  always_comb begin
    sum_a = xdm_pkg::SUM_W'(fwd) + xdm_pkg::SUM_W'(side);
    sum_b = xdm_pkg::SUM_W'(fwd) - xdm_pkg::SUM_W'(side);
    mag_a = sum_a[xdm_pkg::SUM_W-1] ? xdm_pkg::SUM_W'(-sum_a) : xdm_pkg::SUM_W'(sum_a);
    mag_b = sum_b[xdm_pkg::SUM_W-1] ? xdm_pkg::SUM_W'(-sum_b) : xdm_pkg::SUM_W'(sum_b);
    prod_a_nxt = xdm_pkg::PROD_W'(mag_a) * xdm_pkg::PROD_W'(xdm_pkg::MIX_COEF);
    prod_b_nxt = xdm_pkg::PROD_W'(mag_b) * xdm_pkg::PROD_W'(xdm_pkg::MIX_COEF);
  end

  always_ff @(posedge clk) begin
    if (en_s0) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
      neg_a_r  <= sum_a[xdm_pkg::SUM_W-1];
      neg_b_r  <= sum_b[xdm_pkg::SUM_W-1];
      turn_r   <= turn;
    end
  end

  always_comb begin
    rnd_a = prod_a_r + xdm_pkg::MIX_HALF;
    rnd_b = prod_b_r + xdm_pkg::MIX_HALF;
    dg_a  = rnd_a[xdm_pkg::PROD_W-1:xdm_pkg::MIX_SHIFT];
    dg_b  = rnd_b[xdm_pkg::PROD_W-1:xdm_pkg::MIX_SHIFT];
    da    = neg_a_r ? -$signed({1'b0, dg_a}) : $signed({1'b0, dg_a});
    db    = neg_b_r ? -$signed({1'b0, dg_b}) : $signed({1'b0, dg_b});
    tw    = xdm_pkg::WHL_W'(turn_r);
    whl_nxt[xdm_pkg::WHL_FL] = da + tw;
    whl_nxt[xdm_pkg::WHL_FR] = db - tw;
    whl_nxt[xdm_pkg::WHL_BL] = db + tw;
    whl_nxt[xdm_pkg::WHL_BR] = da - tw;
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      whl_r <= whl_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xdm_sat.sv */
// Desaturation front end: wheel magnitudes, largest magnitude, limit check,
// then numerator products for the divider. Two register stages. Uses xdm_pkg.
`default_nettype none

module xdm_sat (
  input  logic                                clk,
  input  logic                                en_s2,
  input  logic                                en_s3,
  input  xdm_pkg::whl_t [xdm_pkg::LANES-1:0]  whl,
  input  logic [xdm_pkg::LIM_W-1:0]           lim,
  output xdm_pkg::div_t                       div_r
);

  logic [xdm_pkg::LANES-1:0][xdm_pkg::MAG_W-1:0] mag;
  logic [xdm_pkg::LANES-1:0]                     neg;
  logic [xdm_pkg::MAG_W-1:0]                     max_lo;
  logic [xdm_pkg::MAG_W-1:0]                     max_hi;
  logic [xdm_pkg::MAG_W-1:0]                     max_all;

  logic [xdm_pkg::LANES-1:0][xdm_pkg::MAG_W-1:0] mag2_r;
  logic [xdm_pkg::LANES-1:0]                     neg2_r;
  logic [xdm_pkg::MAG_W-1:0]                     max2_r;
  logic                                          scl2_r;

  xdm_pkg::div_t                                 div_nxt;

  always_comb begin
    for (int i = 0; i < xdm_pkg::LANES; i++) begin
      neg[i] = whl[i][xdm_pkg::WHL_W-1];
      mag[i] = neg[i] ? xdm_pkg::MAG_W'(-whl[i]) : xdm_pkg::MAG_W'(whl[i]);
    end
    max_lo  = (mag[0] > mag[1]) ? mag[0] : mag[1];
    max_hi  = (mag[2] > mag[3]) ? mag[2] : mag[3];
    max_all = (max_lo > max_hi) ? max_lo : max_hi;
  end

  always_ff @(posedge clk) begin
    if (en_s2) begin
      mag2_r <= mag;
      neg2_r <= neg;
      max2_r <= max_all;
      scl2_r <= max_all > xdm_pkg::MAG_W'(lim);
    end
  end

  always_comb begin
    for (int i = 0; i < xdm_pkg::LANES; i++) begin
      div_nxt.lane[i].neg  = neg2_r[i];
      div_nxt.lane[i].rem  = xdm_pkg::NUM_W'(mag2_r[i]) * xdm_pkg::NUM_W'(lim);
      div_nxt.lane[i].quo  = '0;
      div_nxt.lane[i].pass = mag2_r[i][xdm_pkg::Q_W-1:0];
    end
    div_nxt.dvsr   = xdm_pkg::NUM_W'(max2_r) << (xdm_pkg::Q_W - 1);
    div_nxt.scaled = scl2_r;
  end

  always_ff @(posedge clk) begin
    if (en_s3) begin
      div_r <= div_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xdm_div_stage.sv */
// One restoring-division step for all four wheels: one quotient bit per lane.
// The divisor travels pre-shifted and moves down one bit each step. Uses xdm_pkg.
`default_nettype none

module xdm_div_stage (
  input  logic          clk,
  input  logic          en,
  input  xdm_pkg::div_t d_in,
  output xdm_pkg::div_t d_r
);

  xdm_pkg::div_t             d_nxt;
  logic [xdm_pkg::LANES-1:0] ge;

  always_comb begin
    d_nxt = d_in;
    for (int i = 0; i < xdm_pkg::LANES; i++) begin
      ge[i] = d_in.lane[i].rem >= d_in.dvsr;
      d_nxt.lane[i].rem = ge[i] ? d_in.lane[i].rem - d_in.dvsr : d_in.lane[i].rem;
      d_nxt.lane[i].quo = {d_in.lane[i].quo[xdm_pkg::Q_W-2:0], ge[i]};
    end
    d_nxt.dvsr = d_in.dvsr >> 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/x_drive_wheel_mixer.sv */
// X-drive wheel mixer: turns a forward/sideways/turn command into four wheel
// speeds, scaling all four by limit/largest when the largest magnitude
// exceeds the configured limit. It takes one item per clock unless the output
// stalls with every stage full; each item passes through sixteen register
// stages: two mixing stages, two stages for the magnitude check and
// numerator products, eleven restoring-division stages (one quotient bit
// each) and the output register. A stalled output fills empty stages first,
// so items keep entering while bubbles remain.
// Depends on xdm_pkg, xdm_in_if, xdm_out_if, xdm_mix, xdm_sat, xdm_div_stage.
`default_nettype none

module x_drive_wheel_mixer (
  input  logic                        clk,
  input  logic                        rst_n,
  xdm_in_if.sink                      in_ch,
  xdm_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [xdm_pkg::LIM_W-1:0]   cfg_wdata
);

  localparam int NSTG = xdm_pkg::NSTG;
  localparam int DSTG = xdm_pkg::Q_W;

  logic [xdm_pkg::LIM_W-1:0]            lim_r;
  logic [NSTG-1:0]                      vld_r;
  logic [NSTG-1:0]                      vld_nxt;
  logic [NSTG-1:0]                      en;
  logic [NSTG-1:0]                      bub;

  xdm_pkg::whl_t [xdm_pkg::LANES-1:0]   whl;
  xdm_pkg::div_t                        stg [DSTG+1];

  xdm_pkg::spd_t [xdm_pkg::LANES-1:0]   res_r;
  xdm_pkg::spd_t [xdm_pkg::LANES-1:0]   res_nxt;
  logic                                 scl_r;
  logic [xdm_pkg::Q_W-1:0]              mag_fin [xdm_pkg::LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= xdm_pkg::LIM_RST;
    end else if (cfg_we) begin
      lim_r <= cfg_wdata;
    end
  end

  // a stage advances when the output is taken or any stage at or after it is empty
  always_comb begin
    bub = ~vld_r;
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_ch.ready || ((bub >> k) != '0);
    end
    vld_nxt[0] = en[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = en[0];

  xdm_mix u_mix (
    .clk   (clk),
    .en_s0 (en[0]),
    .en_s1 (en[1]),
    .fwd   (in_ch.forward_speed),
    .side  (in_ch.sideways_speed),
    .turn  (in_ch.turn_speed),
    .whl_r (whl)
  );

  xdm_sat u_sat (
    .clk   (clk),
    .en_s2 (en[2]),
    .en_s3 (en[3]),
    .whl   (whl),
    .lim   (lim_r),
    .div_r (stg[0])
  );

  for (genvar j = 0; j < DSTG; j++) begin : g_div
    xdm_div_stage u_div (
      .clk  (clk),
      .en   (en[4+j]),
      .d_in (stg[j]),
      .d_r  (stg[j+1])
    );
  end

  always_comb begin
    for (int i = 0; i < xdm_pkg::LANES; i++) begin
      mag_fin[i] = stg[DSTG].scaled ? stg[DSTG].lane[i].quo : stg[DSTG].lane[i].pass;
      res_nxt[i] = stg[DSTG].lane[i].neg ? -$signed({1'b0, mag_fin[i]})
                                         : $signed({1'b0, mag_fin[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      res_r <= res_nxt;
      scl_r <= stg[DSTG].scaled;
    end
  end

  assign out_ch.valid             = vld_r[NSTG-1];
  assign out_ch.front_left_speed  = res_r[xdm_pkg::WHL_FL];
  assign out_ch.front_right_speed = res_r[xdm_pkg::WHL_FR];
  assign out_ch.back_left_speed   = res_r[xdm_pkg::WHL_BL];
  assign out_ch.back_right_speed  = res_r[xdm_pkg::WHL_BR];
  assign out_ch.was_scaled        = scl_r;

endmodule

`default_nettype wire

/* hw/rtl/xdm_chk.sv */
// Port-level checker for the X-drive wheel mixer and its bind to the top level.
// Tracks items in flight from the handshakes. Depends on xdm_pkg.
`default_nettype none

module xdm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [xdm_pkg::SPD_W-1:0]   fl,
  input logic [xdm_pkg::SPD_W-1:0]   fr,
  input logic [xdm_pkg::SPD_W-1:0]   bl,
  input logic [xdm_pkg::SPD_W-1:0]   br,
  input logic                        scaled
);

  localparam int CNT_W = $clog2(xdm_pkg::NSTG + 1);
  localparam logic [CNT_W-1:0]          CNT_FULL = CNT_W'(xdm_pkg::NSTG);
  localparam logic [xdm_pkg::SPD_W-1:0] SPD_MIN  = {1'b1, {(xdm_pkg::SPD_W-1){1'b0}}};

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(in_valid && in_ready) - CNT_W'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({fl, fr, bl, br, scaled}))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result shown with no item in flight");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> cnt_r == CNT_FULL)
    else $error("input stalled while pipeline has room");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("more items in flight than pipeline stages");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fl != SPD_MIN && fr != SPD_MIN && bl != SPD_MIN && br != SPD_MIN)
    else $error("wheel speed out of range");

endmodule

bind x_drive_wheel_mixer xdm_chk u_xdm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .fl        (out_ch.front_left_speed),
  .fr        (out_ch.front_right_speed),
  .bl        (out_ch.back_left_speed),
  .br        (out_ch.back_right_speed),
  .scaled    (out_ch.was_scaled)
);

`default_nettype wire

/* tb/sv/xdm_checker.sv */
// Scoreboard for the X-drive wheel mixer: watches the command, result and
// limit ports, predicts the four wheel speeds and the scaled flag, compares.
// Depends on xdm_pkg, xdm_in_if and xdm_out_if.
`default_nettype none

module xdm_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  xdm_in_if                         in_ch,
  xdm_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [xdm_pkg::LIM_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int INV_SQRT2_Q15 = 23170;
  localparam int ROUND_HALF    = 16384;

  typedef struct packed {
    xdm_pkg::spd_t fl;
    xdm_pkg::spd_t fr;
    xdm_pkg::spd_t bl;
    xdm_pkg::spd_t br;
    logic          scaled;
  } wheels_t;

  wheels_t                   expected_wheels[$];
  logic [xdm_pkg::LIM_W-1:0] limit_now = xdm_pkg::LIM_RST;

  function automatic int rot45(int s);
    int r;
    r = ((s < 0 ? -s : s) * INV_SQRT2_Q15 + ROUND_HALF) >>> 15;
    return s < 0 ? -r : r;
  endfunction

  function automatic wheels_t mix_wheels(xdm_pkg::spd_t fwd, xdm_pkg::spd_t side,
                                         xdm_pkg::spd_t turn,
                                         logic [xdm_pkg::LIM_W-1:0] lim);
    int      da;
    int      db;
    int      peak;
    int      lim_i;
    int      q;
    int      w[4];
    wheels_t r;
    da = rot45(int'(fwd) + int'(side));
    db = rot45(int'(fwd) - int'(side));
    w[xdm_pkg::WHL_FL] = da + int'(turn);
    w[xdm_pkg::WHL_FR] = db - int'(turn);
    w[xdm_pkg::WHL_BL] = db + int'(turn);
    w[xdm_pkg::WHL_BR] = da - int'(turn);
    lim_i = int'(lim);
    peak = 0;
    for (int k = 0; k < xdm_pkg::LANES; k++) begin
      if ((w[k] < 0 ? -w[k] : w[k]) > peak) peak = (w[k] < 0 ? -w[k] : w[k]);
    end
    r.scaled = peak > lim_i;
    if (r.scaled) begin
      for (int k = 0; k < xdm_pkg::LANES; k++) begin
        q = ((w[k] < 0 ? -w[k] : w[k]) * lim_i) / peak;
        w[k] = w[k] < 0 ? -q : q;
      end
    end
    r.fl = xdm_pkg::spd_t'(w[xdm_pkg::WHL_FL]);
    r.fr = xdm_pkg::spd_t'(w[xdm_pkg::WHL_FR]);
    r.bl = xdm_pkg::spd_t'(w[xdm_pkg::WHL_BL]);
    r.br = xdm_pkg::spd_t'(w[xdm_pkg::WHL_BR]);
    return r;
  endfunction

  function automatic int field_diff(string name, int want, int got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    wheels_t want;
    int      errs;
    if (!rst_n) begin
      limit_now = xdm_pkg::LIM_RST;
      expected_wheels.delete();
      fail_count <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_wheels.size() == 0) begin
          $display("%0t: unexpected item, expected none, got fl=%0d fr=%0d bl=%0d br=%0d s=%0d",
                   $time, out_ch.front_left_speed, out_ch.front_right_speed,
                   out_ch.back_left_speed, out_ch.back_right_speed, out_ch.was_scaled);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_wheels.pop_front();
          errs = field_diff("front_left_speed", want.fl, out_ch.front_left_speed)
               + field_diff("front_right_speed", want.fr, out_ch.front_right_speed)
               + field_diff("back_left_speed", want.bl, out_ch.back_left_speed)
               + field_diff("back_right_speed", want.br, out_ch.back_right_speed)
               + field_diff("was_scaled", want.scaled, out_ch.was_scaled);
          fail_count <= fail_count + errs;
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_wheels.push_back(mix_wheels(in_ch.forward_speed, in_ch.sideways_speed,
                                             in_ch.turn_speed, limit_now));
      if (cfg_we) limit_now = cfg_wdata;
    end
    pending <= expected_wheels.size();
  end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Top of the X-drive wheel mixer testbench: clock, reset, command and limit
// stimulus, result back-pressure and the verdict. Depends on xdm_pkg, both
// channel interfaces, x_drive_wheel_mixer and xdm_checker.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 125;
  localparam int SETTLE_CYCLES = 20;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [xdm_pkg::LIM_W-1:0] cfg_wdata;
  int                        fail_count;
  int                        pending;
  int                        cycle_cnt = 0;
  bit                        tx_idle_on = 1'b1;
  bit                        rx_idle_on = 1'b1;
  bit                        hold_req = 1'b0;

  xdm_in_if  in_ch ();
  xdm_out_if out_ch ();

  x_drive_wheel_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  xdm_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(99) < 18);
      end
    end
  end

  task automatic send_cmd(input int fwd, input int side, input int turn);
    while (tx_idle_on && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.forward_speed  <= xdm_pkg::spd_t'(fwd);
    in_ch.sideways_speed <= xdm_pkg::spd_t'(side);
    in_ch.turn_speed     <= xdm_pkg::spd_t'(turn);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_random(input logic [xdm_pkg::LIM_W-1:0] lim);
    int span;
    int turn;
    span = int'(lim);
    case ($urandom_range(4))
      0, 1: send_cmd(rand_span(2048) % 2048 - (($urandom_range(9) == 0) ? 1 : 0),
                     int'($urandom_range(0, 4095)) - 2048,
                     int'($urandom_range(0, 4095)) - 2048);
      2: send_cmd(rand_span(span / 2 + 1), rand_span(span / 2 + 1), rand_span(span / 2 + 1));
      3: begin
        turn = span + int'($urandom_range(0, 2)) - 1;
        send_cmd(0, 0, $urandom_range(1) ? -turn : turn);
      end
      default: send_cmd(rand_span(span), rand_span(span), rand_span(span));
    endcase
  endtask

  task automatic write_limit(input logic [xdm_pkg::LIM_W-1:0] lim);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [xdm_pkg::LIM_W-1:0] lim;
    int                        ph;
    int                        n;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_ch.valid          = 1'b0;
    in_ch.forward_speed  = '0;
    in_ch.sideways_speed = '0;
    in_ch.turn_speed     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(0, 0, 0);
    send_cmd(2047, 0, 0);
    send_cmd(-2048, 0, 0);
    send_cmd(0, 2047, 0);
    send_cmd(0, -2048, 0);
    send_cmd(0, 0, 2047);
    send_cmd(0, 0, -2048);
    send_cmd(2047, 2047, 2047);
    send_cmd(-2048, -2048, -2048);
    send_cmd(2047, -2048, -2048);
    send_cmd(-2048, 2047, 2047);
    send_cmd(0, 0, 600);
    send_cmd(0, 0, -601);
    send_cmd(1, -1, 0);
    send_cmd(-1, 0, 1);
    send_cmd(300, 200, -100);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       lim = '1;
        1:       lim = 11'd1;
        2:       lim = '0;
        3:       lim = xdm_pkg::LIM_RST;
        default: lim = xdm_pkg::LIM_W'($urandom_range(1, 2047));
      endcase
      write_limit(lim);
      if (ph == 2) begin
        send_cmd(0, 0, 0);
        send_cmd(5, 0, 0);
        send_cmd(-2048, 2047, -1);
      end
      tx_idle_on = (ph != 4);
      rx_idle_on = (ph != 4);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == 40) hold_req = 1'b1;
        send_random(lim);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
